// ===== hdl/imugdd_pkg.sv =====
// Shared types and constants for the IMU dot/dash gesture classifier.
// No dependencies; used by every module in hdl/.
`default_nettype none

package imugdd_pkg;

	localparam int unsigned SYMBOL_LIMIT = 37;   // symbols per run before the buffer is full
	localparam int unsigned COUNT_W      = 6;
	localparam int unsigned REG_W        = 15;
	localparam int unsigned AXIS_W       = 16;
	localparam int unsigned MAG_W        = 17;   // |-32768| and |az - 1 g| need one more bit
	localparam int unsigned CFG_IDX_W    = 3;

	localparam logic signed [AXIS_W-1:0] INVALID_MARK = 16'shC000;   // -4 g
	localparam logic signed [MAG_W-1:0]  ONE_G        = 17'sd4096;

	typedef enum logic [1:0] {
		SYM_NONE = 2'd0,
		SYM_DOT  = 2'd1,
		SYM_DASH = 2'd2,
		SYM_FULL = 2'd3
	} sym_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAKE_RATE_XY = 3'd0,
		REG_SHAKE_RATE_Z  = 3'd1,
		REG_SHAKE_ACCEL_X = 3'd2,
		REG_LIFT_ACCEL_Y  = 3'd3,
		REG_LIFT_RATE_MIN = 3'd4,
		REG_DASH_DIST     = 3'd5,
		REG_DASH_Z_TOL    = 3'd6,
		REG_DASH_RATE_Z   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] shake_rate_xy_threshold;
		logic [REG_W-1:0] shake_rate_z_threshold;
		logic [REG_W-1:0] shake_accel_x_threshold;
		logic [REG_W-1:0] lift_accel_y_threshold;
		logic [REG_W-1:0] lift_rate_min;
		logic [REG_W-1:0] dash_distance_threshold;
		logic [REG_W-1:0] dash_z_tolerance;
		logic [REG_W-1:0] dash_rate_z_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] rate_z;
		logic signed [AXIS_W-1:0] rate_y;
		logic signed [AXIS_W-1:0] rate_x;
		logic signed [AXIS_W-1:0] accel_z;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_x;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0] symbol_count;
		logic [AXIS_W-1:0]  peak_level;
		logic               peak_seen;
		logic               lift_latched;
	} gest_state_t;

endpackage

`default_nettype wire

// ===== hdl/imu_gesture_dot_dash_classifier_top.sv =====
// Top level of the IMU dot/dash gesture classifier: stream ports, input and result registers.
// Depends on imugdd_pkg, imugdd_cfg_regs and imugdd_classify.
//
//  Channel   Dir   Handshake                       Payload
//  s_axis    in    s_axis_tvalid / s_axis_tready   tdata: 6 x 16-bit sample, tuser: restart
//  m_axis    out   m_axis_tvalid / m_axis_tready   tdata: symbol_total, tuser: symbol_code
//  cfg       in    cfg_valid / cfg_ready           cfg_index, cfg_data (threshold write)
//
// Each input beat gives exactly one output beat. A beat is held in the input
// register, is classified in a single combinational pass against the tracker state,
// and lands in the result register: one beat per cycle sustained while m_axis_tready is high.
// The tracker state (count, peak, latches) updates as the beat moves to the result register.
// Reset clears the valid flags and tracker state and loads the default thresholds.
// A stalled m_axis holds the result; the input register still takes a beat while the
// result register is free or draining, so s_axis_tready drops only when both are full.
// cfg_ready is always high; writes are expected only while the block is idle.
`default_nettype none

module imu_gesture_dot_dash_classifier_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata, low bit up: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  wire logic [95:0]                         s_axis_tdata,
	// tuser: restart
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// tdata, low bit up: symbol_total [5:0], zero pad [7:6]
	output logic [7:0]                               m_axis_tdata,
	// tuser: symbol_code
	output logic [1:0]                               m_axis_tuser,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [imugdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [imugdd_pkg::REG_W-1:0]        cfg_data
);

	imugdd_pkg::cfg_t         cfg;
	imugdd_pkg::sample_t      sample_s1;
	logic                     restart_s1;
	logic                     valid_s1;
	logic                     valid_s2;
	imugdd_pkg::sym_code_t    code_s2;
	logic [imugdd_pkg::COUNT_W-1:0] total_s2;
	imugdd_pkg::gest_state_t  state_q;
	imugdd_pkg::gest_state_t  state_nxt;
	imugdd_pkg::sym_code_t    code_nxt;
	logic                     adv_s2;
	logic                     take_s1;

	assign cfg_ready = 1'b1;

	imugdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	imugdd_classify u_classify (
		.sample    (sample_s1),
		.restart   (restart_s1),
		.state_cur (state_q),
		.cfg       (cfg),
		.state_nxt (state_nxt),
		.code      (code_nxt)
	);

	// result register can load when empty or being drained this cycle
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign take_s1       = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1  <= imugdd_pkg::sample_t'(s_axis_tdata);
			restart_s1 <= s_axis_tuser;
		end
	end

	// result register and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (take_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			code_s2  <= code_nxt;
			total_s2 <= state_nxt.symbol_count;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, total_s2};
	assign m_axis_tuser  = code_s2;

endmodule

`default_nettype wire

// ===== hdl/imugdd_cfg_regs.sv =====
// Threshold register file for the gesture classifier.
// Depends on imugdd_pkg (cfg_t, reg_idx_t).
`default_nettype none

module imugdd_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [imugdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [imugdd_pkg::REG_W-1:0]        cfg_data,
	output imugdd_pkg::cfg_t                         cfg
);

	imugdd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shake_rate_xy_threshold <= 15'd800;
			cfg_q.shake_rate_z_threshold  <= 15'd1600;
			cfg_q.shake_accel_x_threshold <= 15'd3686;
			cfg_q.lift_accel_y_threshold  <= 15'd614;
			cfg_q.lift_rate_min           <= 15'd48;
			cfg_q.dash_distance_threshold <= 15'd1229;
			cfg_q.dash_z_tolerance        <= 15'd819;
			cfg_q.dash_rate_z_limit       <= 15'd384;
		end else if (cfg_valid) begin
			unique case (imugdd_pkg::reg_idx_t'(cfg_index))
				imugdd_pkg::REG_SHAKE_RATE_XY: cfg_q.shake_rate_xy_threshold <= cfg_data;
				imugdd_pkg::REG_SHAKE_RATE_Z:  cfg_q.shake_rate_z_threshold  <= cfg_data;
				imugdd_pkg::REG_SHAKE_ACCEL_X: cfg_q.shake_accel_x_threshold <= cfg_data;
				imugdd_pkg::REG_LIFT_ACCEL_Y:  cfg_q.lift_accel_y_threshold  <= cfg_data;
				imugdd_pkg::REG_LIFT_RATE_MIN: cfg_q.lift_rate_min           <= cfg_data;
				imugdd_pkg::REG_DASH_DIST:     cfg_q.dash_distance_threshold <= cfg_data;
				imugdd_pkg::REG_DASH_Z_TOL:    cfg_q.dash_z_tolerance        <= cfg_data;
				imugdd_pkg::REG_DASH_RATE_Z:   cfg_q.dash_rate_z_limit       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/imugdd_classify.sv =====
// Single-pass classification of one sample: dot/dash decision and next tracker state.
// Depends on imugdd_pkg (sample_t, gest_state_t, cfg_t, sym_code_t).
`default_nettype none

module imugdd_classify (
	input  wire imugdd_pkg::sample_t      sample,
	input  wire logic                     restart,
	input  wire imugdd_pkg::gest_state_t  state_cur,
	input  wire imugdd_pkg::cfg_t         cfg,
	output imugdd_pkg::gest_state_t       state_nxt,
	output imugdd_pkg::sym_code_t         code
);

	localparam int unsigned MW = imugdd_pkg::MAG_W;

	function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
		logic signed [MW-1:0] n;
		begin
			n = -v;
			mag = v[MW-1] ? n : v;
		end
	endfunction

	logic [MW-1:0] max_a, may_a, maz1, mgx, mgy, mgz;
	logic [MW-1:0] rxy, rz, rax, ray, rmin, rztol, rzlim;
	logic signed [MW:0] drop_amt;
	logic signed [MW:0] rdist;
	logic shake, rd_ok, lift_start;
	imugdd_pkg::gest_state_t st0, st1;

	always_comb begin
		max_a = mag(MW'(sample.accel_x));
		may_a = mag(MW'(sample.accel_y));
		maz1  = mag(MW'(sample.accel_z) - imugdd_pkg::ONE_G);
		mgx   = mag(MW'(sample.rate_x));
		mgy   = mag(MW'(sample.rate_y));
		mgz   = mag(MW'(sample.rate_z));

		rxy   = MW'(cfg.shake_rate_xy_threshold);
		rz    = MW'(cfg.shake_rate_z_threshold);
		rax   = MW'(cfg.shake_accel_x_threshold);
		ray   = MW'(cfg.lift_accel_y_threshold);
		rmin  = MW'(cfg.lift_rate_min);
		rztol = MW'(cfg.dash_z_tolerance);
		rzlim = MW'(cfg.dash_rate_z_limit);
		rdist = (MW+1)'({1'b0, cfg.dash_distance_threshold});

		shake = (mgx > rxy) || (mgy > rxy) || (mgz > rz);
		rd_ok = (sample.accel_x != imugdd_pkg::INVALID_MARK)
			&& (sample.accel_y != imugdd_pkg::INVALID_MARK)
			&& (sample.accel_z != imugdd_pkg::INVALID_MARK);
		lift_start = (may_a > ray)
			&& ((mgz > rmin) || (mgx > rmin) || (mgy > rmin))
			&& (mgz < rz) && (mgx < rxy) && (mgy < rxy);

		// restart clears before the sample is looked at
		st0 = restart ? '0 : state_cur;
		st1 = st0;
		code = imugdd_pkg::SYM_NONE;
		drop_amt = '0;

		if (st0.symbol_count >= imugdd_pkg::COUNT_W'(imugdd_pkg::SYMBOL_LIMIT)) begin
			code = imugdd_pkg::SYM_FULL;
		end else if (shake && (max_a > rax) && rd_ok) begin
			code = imugdd_pkg::SYM_DOT;
			st1.symbol_count = st0.symbol_count + 1'b1;
			st1.peak_seen    = 1'b0;
			st1.lift_latched = 1'b0;
		end else if (lift_start || st0.lift_latched) begin
			st1.lift_latched = 1'b1;
			// |ay| never exceeds 32768, so it fits the 16-bit peak
			if ((may_a >= MW'(st0.peak_level)) && !st0.peak_seen)
				st1.peak_level = may_a[imugdd_pkg::AXIS_W-1:0];
			else
				st1.peak_seen = 1'b1;
			drop_amt = $signed({2'b00, st1.peak_level}) - (MW+1)'(sample.accel_y);
			if (st1.peak_seen && (maz1 < rztol) && (mgz < rzlim) && (drop_amt > rdist)) begin
				code = imugdd_pkg::SYM_DASH;
				st1.symbol_count = st0.symbol_count + 1'b1;
				st1.peak_seen    = 1'b0;
				st1.peak_level   = '0;
				st1.lift_latched = 1'b0;
			end
		end
		state_nxt = st1;
	end

endmodule

`default_nettype wire

// ===== dv/imu_gesture_dot_dash_classifier_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for imu_gesture_dot_dash_classifier_top: streams IMU samples and
// threshold writes into the block and checks every dot/dash result against an in-bench model.
// Depends on imugdd_pkg and the RTL under hdl/.

module imu_gesture_dot_dash_classifier_top_tb;

	localparam int HOLD_CYCLES = 300;                  // long result-side hold-off
	localparam int ONE_G_Q12   = imugdd_pkg::ONE_G;    // 1 g in Q4.12

	typedef struct packed {
		imugdd_pkg::sym_code_t          code;
		logic [imugdd_pkg::COUNT_W-1:0] total;
	} symbol_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [95:0]                      s_axis_tdata;   // low bit up: accel_x, accel_y, accel_z, rate_x..z
	logic                             s_axis_tuser;   // restart
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [7:0]                       m_axis_tdata;   // low bit up: symbol_total [5:0], zero pad [7:6]
	logic [1:0]                       m_axis_tuser;   // symbol_code
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [imugdd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [imugdd_pkg::REG_W-1:0]     cfg_data;

	// Model of the tracker, its thresholds and the results still owed by the block
	imugdd_pkg::cfg_t thr;
	int      count_m;
	int      peak_m;
	bit      peak_seen_m;
	bit      lift_m;
	symbol_t pending_symbols[$];

	int mismatch_cnt;
	int beats_sent;
	int send_idle_pct;
	int recv_stall_pct;
	int restart_pct;
	int hold_requests;   // bumped by a test; the result sink serves each with one long hold

	imu_gesture_dot_dash_classifier_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#5_000_000;
		$display("imu_gesture_dot_dash_classifier_top regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------- helpers

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int pick(int lo, int hi);
		return (hi >= lo) ? lo + int'($urandom_range(hi - lo)) : hi;
	endfunction

	function automatic bit coin(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [15:0] sat16(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic imugdd_pkg::sample_t make_sample(int ax, int ay, int az,
		int gx, int gy, int gz);
		imugdd_pkg::sample_t s;
		s.accel_x = sat16(ax);
		s.accel_y = sat16(ay);
		s.accel_z = sat16(az);
		s.rate_x  = sat16(gx);
		s.rate_y  = sat16(gy);
		s.rate_z  = sat16(gz);
		return s;
	endfunction

	function automatic logic [15:0] extreme_word();
		case ($urandom_range(4))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return imugdd_pkg::INVALID_MARK;
			default: return 16'(ONE_G_Q12);
		endcase
	endfunction

	// Rate small enough never to count as shake under the current thresholds
	function automatic int quiet_rate();
		int q;
		q = 40;
		if (thr.shake_rate_xy_threshold < q)
			q = thr.shake_rate_xy_threshold;
		if (thr.shake_rate_z_threshold < q)
			q = thr.shake_rate_z_threshold;
		return pick(-q, q);
	endfunction

	function automatic imugdd_pkg::cfg_t default_thresholds();
		return '{shake_rate_xy_threshold: 15'd800,  shake_rate_z_threshold: 15'd1600,
			shake_accel_x_threshold: 15'd3686, lift_accel_y_threshold: 15'd614,
			lift_rate_min: 15'd48, dash_distance_threshold: 15'd1229,
			dash_z_tolerance: 15'd819, dash_rate_z_limit: 15'd384};
	endfunction

	// ---------------------------------------------------------------- prediction

	// Classifies one accepted sample against the model state and queues the result.
	function automatic void classify_sample(imugdd_pkg::sample_t s, logic restart);
		int ay, mag_ax, mag_ay, mag_az1, mag_gx, mag_gy, mag_gz;
		int rxy, rz, rmin, ax_min, ay_min, drop_min, z_tol, gz_lim, drop;
		bit shake, readable, lift_start;
		symbol_t r;
		ay      = $signed(s.accel_y);
		mag_ax  = magnitude($signed(s.accel_x));
		mag_ay  = magnitude(ay);
		mag_az1 = magnitude($signed(s.accel_z) - ONE_G_Q12);
		mag_gx  = magnitude($signed(s.rate_x));
		mag_gy  = magnitude($signed(s.rate_y));
		mag_gz  = magnitude($signed(s.rate_z));
		rxy      = thr.shake_rate_xy_threshold;
		rz       = thr.shake_rate_z_threshold;
		ax_min   = thr.shake_accel_x_threshold;
		ay_min   = thr.lift_accel_y_threshold;
		rmin     = thr.lift_rate_min;
		drop_min = thr.dash_distance_threshold;
		z_tol    = thr.dash_z_tolerance;
		gz_lim   = thr.dash_rate_z_limit;
		r.code   = imugdd_pkg::SYM_NONE;

		if (restart) begin
			count_m     = 0;
			peak_m      = 0;
			peak_seen_m = 1'b0;
			lift_m      = 1'b0;
		end

		if (count_m >= imugdd_pkg::SYMBOL_LIMIT) begin
			r.code = imugdd_pkg::SYM_FULL;
		end else begin
			shake    = mag_gx > rxy || mag_gy > rxy || mag_gz > rz;
			readable = s.accel_x != imugdd_pkg::INVALID_MARK
				&& s.accel_y != imugdd_pkg::INVALID_MARK
				&& s.accel_z != imugdd_pkg::INVALID_MARK;
			lift_start = mag_ay > ay_min
				&& (mag_gz > rmin || mag_gx > rmin || mag_gy > rmin)
				&& (mag_gz < rz && mag_gx < rxy && mag_gy < rxy);

			if (shake && mag_ax > ax_min && readable) begin
				// dot; a running lift is dropped but its peak level is kept
				r.code = imugdd_pkg::SYM_DOT;
				count_m++;
				peak_seen_m = 1'b0;
				lift_m      = 1'b0;
			end else if (lift_start || lift_m) begin
				lift_m = 1'b1;
				if (mag_ay >= peak_m && !peak_seen_m)
					peak_m = mag_ay;
				else
					peak_seen_m = 1'b1;
				drop = peak_m - ay;
				if (peak_seen_m && mag_az1 < z_tol && mag_gz < gz_lim && drop > drop_min) begin
					r.code = imugdd_pkg::SYM_DASH;
					count_m++;
					peak_seen_m = 1'b0;
					peak_m      = 0;
					lift_m      = 1'b0;
				end
			end
		end
		r.total = imugdd_pkg::COUNT_W'(count_m);
		pending_symbols.push_back(r);
	endfunction

	// ---------------------------------------------------------------- drivers

	// One sample beat; the expectation is queued at the accepting edge.
	task automatic send_sample(imugdd_pkg::sample_t s, logic restart);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		s_axis_tuser  <= restart;
		do @(posedge clk); while (!s_axis_tready);
		classify_sample(s, restart);
		beats_sent++;
		while (coin(send_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Writes all eight thresholds back to back; only called with the block idle.
	task automatic program_thresholds(imugdd_pkg::cfg_t c);
		imugdd_pkg::reg_idx_t idx;
		idx = imugdd_pkg::REG_SHAKE_RATE_XY;
		repeat (idx.num()) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			case (idx)
				imugdd_pkg::REG_SHAKE_RATE_XY: cfg_data <= c.shake_rate_xy_threshold;
				imugdd_pkg::REG_SHAKE_RATE_Z:  cfg_data <= c.shake_rate_z_threshold;
				imugdd_pkg::REG_SHAKE_ACCEL_X: cfg_data <= c.shake_accel_x_threshold;
				imugdd_pkg::REG_LIFT_ACCEL_Y:  cfg_data <= c.lift_accel_y_threshold;
				imugdd_pkg::REG_LIFT_RATE_MIN: cfg_data <= c.lift_rate_min;
				imugdd_pkg::REG_DASH_DIST:     cfg_data <= c.dash_distance_threshold;
				imugdd_pkg::REG_DASH_Z_TOL:    cfg_data <= c.dash_z_tolerance;
				imugdd_pkg::REG_DASH_RATE_Z:   cfg_data <= c.dash_rate_z_limit;
			endcase
			do @(posedge clk); while (!cfg_ready);
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
		thr = c;
	endtask

	// Stops offering samples until every owed result is back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- gestures

	task automatic send_quiet_sample();
		send_sample(make_sample(pick(-300, 300), pick(-300, 300), ONE_G_Q12 + pick(-300, 300),
			quiet_rate(), quiet_rate(), quiet_rate()), coin(restart_pct));
	endtask

	task automatic send_noise_sample();
		imugdd_pkg::sample_t s;
		for (int i = 0; i < 6; i++)
			s[16*i +: 16] = coin(25) ? extreme_word() : 16'($urandom);
		send_sample(s, coin(restart_pct));
	endtask

	// Shake on one rate axis with a large |accel_x|; now and then a reading is marked invalid.
	task automatic send_dot_gesture();
		int sgn, rate, gx, gy, gz, ax, ay, az;
		sgn = coin(50) ? -1 : 1;
		gx  = quiet_rate();
		gy  = quiet_rate();
		gz  = quiet_rate();
		case ($urandom_range(2))
			0: gx = sgn * pick(thr.shake_rate_xy_threshold + 1, thr.shake_rate_xy_threshold + 6000);
			1: gy = sgn * pick(thr.shake_rate_xy_threshold + 1, thr.shake_rate_xy_threshold + 6000);
			default: gz = sgn * pick(thr.shake_rate_z_threshold + 1,
				thr.shake_rate_z_threshold + 6000);
		endcase
		ax = (coin(50) ? -1 : 1) * pick(thr.shake_accel_x_threshold + 1,
			thr.shake_accel_x_threshold + 6000);
		ay = pick(-3000, 3000);
		az = ONE_G_Q12 + pick(-2000, 2000);
		if (coin(10)) begin
			case ($urandom_range(2))
				0:       ax = -16384;
				1:       ay = -16384;
				default: az = -16384;
			endcase
		end
		send_sample(make_sample(ax, ay, az, gx, gy, gz), coin(restart_pct));
	endtask

	// Lift start, rising (or flat) |accel_y|, then a settle; a broken one is cut short.
	task automatic send_dash_gesture(bit broken);
		int sgn, lvl, spin, rlim, gx, gy, gz, drop_min, z_tol, gz_lim;
		sgn      = coin(50) ? -1 : 1;
		drop_min = thr.dash_distance_threshold;
		z_tol    = thr.dash_z_tolerance;
		gz_lim   = thr.dash_rate_z_limit;
		rlim     = (thr.shake_rate_xy_threshold < thr.shake_rate_z_threshold)
			? thr.shake_rate_xy_threshold : thr.shake_rate_z_threshold;
		lvl  = pick(thr.lift_accel_y_threshold + 1, thr.lift_accel_y_threshold + 6000);
		spin = (coin(50) ? -1 : 1) * pick(thr.lift_rate_min + 1, rlim - 1);
		gx   = quiet_rate();
		gy   = quiet_rate();
		gz   = quiet_rate();
		case ($urandom_range(2))
			0:       gx = spin;
			1:       gy = spin;
			default: gz = spin;
		endcase
		send_sample(make_sample(pick(-1000, 1000), sgn * lvl, ONE_G_Q12 + pick(-2000, 2000),
			gx, gy, gz), coin(restart_pct));

		repeat ($urandom_range(3)) begin
			if (!coin(20))
				lvl = lvl + pick(1, 3000);   // otherwise a flat step at the peak
			send_sample(make_sample(pick(-1000, 1000), sgn * lvl, ONE_G_Q12 + pick(-2000, 2000),
				quiet_rate(), quiet_rate(), quiet_rate()), coin(restart_pct));
		end

		if (broken) begin
			if (coin(50))
				send_dot_gesture();
			else
				send_noise_sample();
		end else begin
			// settle: az near 1 g, little z spin, accel_y well below the peak
			repeat ($urandom_range(1, 2))
				send_sample(make_sample(pick(-1000, 1000),
					lvl - pick(drop_min + 1, drop_min + 4000),
					ONE_G_Q12 + pick(-(z_tol - 1), z_tol - 1),
					quiet_rate(), quiet_rate(), pick(-(gz_lim - 1), gz_lim - 1)),
					coin(restart_pct));
		end
	endtask

	// ---------------------------------------------------------------- tests

	// Hand-picked samples under reset thresholds.
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		restart_pct    = 0;
		send_sample(make_sample(0, 0, 4096, 0, 0, 0), 1'b0);                      // nothing
		send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767), 1'b0); // dot
		send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
		// invalid marker on each accel axis blocks an otherwise good dot
		send_sample(make_sample(-16384, 0, 4096, 2000, 0, 0), 1'b0);
		send_sample(make_sample(5000, -16384, 4096, 2000, 0, 0), 1'b0);
		send_sample(make_sample(5000, 0, -16384, 2000, 0, 0), 1'b0);
		// lift at the most negative accel_y: peak of 32768, then dash on settle
		send_sample(make_sample(0, -32768, 4096, 100, 0, 0), 1'b0);
		send_sample(make_sample(0, 0, 4096, 0, 0, 0), 1'b0);
		// rise, flat peak, small drop, failed settles (az, then gz), then a dash
		send_sample(make_sample(0, 1000, 4096, 0, 100, 0), 1'b0);
		send_sample(make_sample(0, 2000, 4096, 0, 0, 0), 1'b0);
		send_sample(make_sample(0, 2000, 4096, 0, 0, 0), 1'b0);
		send_sample(make_sample(0, 1800, 4096, 0, 0, 0), 1'b0);
		send_sample(make_sample(0, 500, 4996, 0, 0, 0), 1'b0);
		send_sample(make_sample(0, 500, 4096, 0, 0, 400), 1'b0);
		send_sample(make_sample(0, 500, 4096, 0, 0, 0), 1'b0);
		// dot in the middle of a lift keeps the peak; the next lift start dashes on it
		send_sample(make_sample(0, 3000, 4096, 0, 0, 100), 1'b0);
		send_sample(make_sample(4000, 0, 4096, 1000, 0, 0), 1'b0);
		send_sample(make_sample(0, 0, 4096, 0, 0, 0), 1'b0);
		send_sample(make_sample(0, 700, 4096, 100, 0, 0), 1'b0);
		// restart together with a sample: cleared first, then classified
		send_sample(make_sample(5000, 0, 4096, 0, 0, 2000), 1'b1);
		send_sample(make_sample(0, 0, 4096, 0, 0, 0), 1'b1);
	endtask

	// Fill the symbol buffer, show that further samples are ignored, then restart.
	task automatic test_symbol_limit();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		restart_pct    = 0;
		send_sample(make_sample(5000, 0, 4096, 2000, 0, 0), 1'b1);
		while (count_m < imugdd_pkg::SYMBOL_LIMIT)
			send_dot_gesture();
		send_dot_gesture();
		send_dash_gesture(1'b0);
		send_noise_sample();
		send_sample(make_sample(0, 0, 4096, 0, 0, 0), 1'b1);
	endtask

	// Mostly well-formed gestures with random content, the rest noise, quiet samples and broken lifts.
	task automatic test_random_gestures(int n, int send_pct, int recv_pct);
		int stop_at, k;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		restart_pct    = 2;
		stop_at        = beats_sent + n;
		while (beats_sent < stop_at) begin
			k = $urandom_range(19);
			if (k < 7)
				send_dash_gesture(1'b0);
			else if (k < 8)
				send_dash_gesture(1'b1);
			else if (k < 13)
				send_dot_gesture();
			else if (k < 17)
				send_noise_sample();
			else
				send_quiet_sample();
		end
	endtask

	// Result side held off for a long stretch while samples keep coming.
	task automatic test_result_backpressure();
		hold_requests++;
		test_random_gestures(60, 0, 0);
		wait_drained();
	endtask

	// Threshold settings from all-zero to all-max, random ones, and back to reset values.
	task automatic test_threshold_sweep();
		imugdd_pkg::cfg_t c;
		int   send_pct[4] = '{0, 54, 0, 21};
		int   recv_pct[4] = '{0, 0, 54, 21};
		for (int k = 0; k < 5; k++) begin
			c = default_thresholds();
			case (k)
				0: c = '0;
				1: c = '1;
				2: for (int i = 0; i < 8; i++)
					c[15*i +: 15] = 15'($urandom);
				3: for (int i = 0; i < 8; i++)
					c[15*i +: 15] = 15'($urandom_range(2 * c[15*i +: 15]));
				default: ;
			endcase
			wait_drained();
			program_thresholds(c);
			test_random_gestures(60, send_pct[k % 4], recv_pct[k % 4]);
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------- result side

	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		symbol_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_symbols.size() == 0) begin
				$error("unexpected result beat: symbol_code %0d symbol_total %0d",
					m_axis_tuser, m_axis_tdata[5:0]);
				mismatch_cnt++;
			end else begin
				want = pending_symbols.pop_front();
				if (m_axis_tuser !== want.code) begin
					$error("symbol_code: expected %0d, got %0d", want.code, m_axis_tuser);
					mismatch_cnt++;
				end
				if (m_axis_tdata[5:0] !== want.total) begin
					$error("symbol_total: expected %0d, got %0d", want.total, m_axis_tdata[5:0]);
					mismatch_cnt++;
				end
				if (m_axis_tdata[7:6] !== 2'b00) begin
					$error("tdata pad: expected 0, got %0d", m_axis_tdata[7:6]);
					mismatch_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : regression
		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		s_axis_tuser   <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= imugdd_pkg::REG_SHAKE_RATE_XY;
		cfg_data       <= '0;
		thr            = default_thresholds();
		count_m        = 0;
		peak_m         = 0;
		peak_seen_m    = 1'b0;
		lift_m         = 1'b0;
		mismatch_cnt   = 0;
		beats_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		restart_pct    = 0;
		hold_requests  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		wait_drained();
		test_symbol_limit();
		wait_drained();
		test_random_gestures(280, 0, 0);
		test_random_gestures(280, 54, 0);
		test_random_gestures(280, 0, 54);
		test_random_gestures(280, 21, 21);
		wait_drained();
		test_result_backpressure();
		test_threshold_sweep();

		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_symbols.size() != 0)
			$error("%0d results never arrived", pending_symbols.size());
		if (mismatch_cnt == 0 && pending_symbols.size() == 0)
			$display("imu_gesture_dot_dash_classifier_top regression: pass");
		else
			$display("imu_gesture_dot_dash_classifier_top regression: fail");
		$finish;
	end

endmodule
